FILE: hw/rtl/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
    `ASSERT_PROP(lbl, !(expr), msg)
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

FILE: hw/rtl/wpm_pkg.sv
package wpm_pkg;

    localparam int PATTERN_BYTES = 1024;
    localparam int IDX_W = $clog2(PATTERN_BYTES);
    localparam int NSLOT = 4;
    localparam logic [IDX_W-1:0] LIMIT = IDX_W'(PATTERN_BYTES - 2);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PATTERN_BYTES - 1);
    localparam logic [7:0] MAX_RUN = 8'd255;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [7:0] EL_ANY = 8'd2;
    localparam logic [7:0] EL_ONE = 8'd3;
    localparam logic [7:0] EL_SET = 8'd4;
    localparam logic [7:0] EL_NSET = 8'd5;
    localparam logic [7:0] EL_TEXT = 8'd6;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NO_PREV = 3'd1;
    localparam logic [2:0] ST_TOO_LONG = 3'd2;
    localparam logic [2:0] ST_PREMATURE = 3'd3;
    localparam logic [2:0] ST_NO_BRACKET = 3'd4;

    localparam logic [2:0] MT_NO = 3'd0;
    localparam logic [2:0] MT_YES = 3'd1;
    localparam logic [2:0] MT_NO_PATTERN = 3'd2;

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT = 1'b1;
    localparam logic KIND_COMPILE = 1'b0;
    localparam logic KIND_MATCH = 1'b1;

    typedef struct packed {
        logic [NSLOT-1:0] we;
        logic [NSLOT-1:0][IDX_W-1:0] addr;
        logic [NSLOT-1:0][7:0] data;
        logic pvalid;
        logic [IDX_W-1:0] end_idx;
        logic [2:0] status;
    } cpl_out_t;

    typedef struct packed {
        logic clr;
        logic shift;
    } set_ctl_t;

endpackage

FILE: hw/rtl/wpm_set_unit.sv
module wpm_set_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  wpm_pkg::set_ctl_t ctl,
    input  logic [7:0]        data,
    input  logic [7:0]        key,
    output logic              hit
);

    logic [7:0] w1_reg, w1_next;
    logic [7:0] w2_reg, w2_next;
    logic [1:0] cnt_reg, cnt_next;
    logic hit_reg, hit_next;
    logic eq, rng;

    // range test at the previous byte once its right bound is here
    assign eq = (data == key);
    assign rng = (cnt_reg == 2'd2) && (w1_reg == wpm_pkg::CH_DASH) &&
                 (w2_reg < key) && (key < data);

    always_comb
    begin
        w1_next = w1_reg;
        w2_next = w2_reg;
        cnt_next = cnt_reg;
        hit_next = hit_reg;
        if (ctl.clr)
        begin
            cnt_next = 2'd0;
            hit_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            hit_next = hit_reg | eq | rng;
            w2_next = w1_reg;
            w1_next = data;
            if (cnt_reg != 2'd2)
            begin
                cnt_next = cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            hit_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w1_reg <= w1_next;
        w2_reg <= w2_next;
    end

    assign hit = hit_reg;

endmodule

FILE: hw/rtl/wpm_compiler.sv
module wpm_compiler (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        ch,
    input  logic              no_char,
    input  logic              last,
    output wpm_pkg::cpl_out_t cpl
);

    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_BETWEEN   = 7'b0000010,
        PH_STAR      = 7'b0000100,
        PH_RUN       = 7'b0001000,
        PH_SET_START = 7'b0010000,
        PH_SET_BODY  = 7'b0100000,
        PH_ERROR     = 7'b1000000
    } phase_t;

    phase_t phase_reg, phase_next;
    logic [wpm_pkg::IDX_W-1:0] wi_reg, wi_next;
    logic [wpm_pkg::IDX_W-1:0] hi_reg, hi_next;
    logic [7:0] rc_reg, rc_next;
    logic esc_reg, esc_next;
    logic nset_reg, nset_next;
    logic pv_reg, pv_next;
    logic [2:0] st_reg, st_next;
    logic [wpm_pkg::NSLOT-1:0] we_reg, we_next;
    logic [wpm_pkg::NSLOT-1:0][wpm_pkg::IDX_W-1:0] wa_reg, wa_next;
    logic [wpm_pkg::NSLOT-1:0][7:0] wd_reg, wd_next;

    always_comb
    begin
        phase_t ph;
        logic [wpm_pkg::IDX_W-1:0] wi;
        logic [wpm_pkg::IDX_W-1:0] hi;
        logic [7:0] rc;
        logic esc;
        logic nset;
        logic pv;
        logic disp;
        logic rb;
        logic ap;
        logic [2:0] st;
        logic [1:0] nw;
        logic [wpm_pkg::NSLOT-1:0] wv;
        logic [wpm_pkg::NSLOT-1:0][wpm_pkg::IDX_W-1:0] wa;
        logic [wpm_pkg::NSLOT-1:0][7:0] wd;

        ph = phase_reg;
        wi = wi_reg;
        hi = hi_reg;
        rc = rc_reg;
        esc = esc_reg;
        nset = nset_reg;
        pv = pv_reg;
        disp = 1'b0;
        rb = 1'b0;
        ap = 1'b0;
        st = wpm_pkg::ST_OK;
        nw = 2'd0;
        wv = '0;
        wa = '0;
        wd = '0;

        if (!no_char)
        begin
            if (ph == PH_IDLE)
            begin
                pv = 1'b0;
                wi = '0;
                hi = '0;
                rc = 8'd0;
                esc = 1'b0;
                ph = PH_BETWEEN;
            end
            unique case (ph)
                PH_STAR:
                begin
                    disp = (ch != wpm_pkg::CH_STAR);
                end
                PH_BETWEEN:
                begin
                    disp = 1'b1;
                end
                PH_RUN:
                begin
                    if (esc)
                    begin
                        esc = 1'b0;
                        ap = 1'b1;
                    end
                    else if (rc >= wpm_pkg::MAX_RUN || ch == wpm_pkg::CH_STAR ||
                             ch == wpm_pkg::CH_QMARK || ch == wpm_pkg::CH_LBRACK)
                    begin
                        disp = 1'b1;
                    end
                    else
                    begin
                        rb = 1'b1;
                    end
                end
                PH_SET_START:
                begin
                    if (ch == wpm_pkg::CH_CARET && !nset)
                    begin
                        nset = 1'b1;
                        wa[nw] = hi;
                        wd[nw] = wpm_pkg::EL_NSET;
                        wv[nw] = 1'b1;
                        nw = nw + 2'd1;
                    end
                    else if (wi >= wpm_pkg::LIMIT)
                    begin
                        ph = PH_ERROR;
                        rc = 8'(wpm_pkg::ST_TOO_LONG);
                        esc = 1'b0;
                    end
                    else
                    begin
                        ap = 1'b1;
                        ph = PH_SET_BODY;
                    end
                end
                PH_SET_BODY:
                begin
                    if (ch == wpm_pkg::CH_RBRACK)
                    begin
                        ph = PH_BETWEEN;
                    end
                    else if (rc >= wpm_pkg::MAX_RUN)
                    begin
                        ph = PH_ERROR;
                        rc = 8'(wpm_pkg::ST_NO_BRACKET);
                        esc = 1'b0;
                    end
                    else if (wi >= wpm_pkg::LIMIT)
                    begin
                        ph = PH_ERROR;
                        rc = 8'(wpm_pkg::ST_TOO_LONG);
                        esc = 1'b0;
                    end
                    else
                    begin
                        ap = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (disp)
            begin
                if (ch == wpm_pkg::CH_STAR || ch == wpm_pkg::CH_QMARK)
                begin
                    if (wi >= wpm_pkg::LIMIT)
                    begin
                        ph = PH_ERROR;
                        rc = 8'(wpm_pkg::ST_TOO_LONG);
                        esc = 1'b0;
                    end
                    else
                    begin
                        wa[nw] = wi;
                        wd[nw] = (ch == wpm_pkg::CH_STAR) ? wpm_pkg::EL_ANY : wpm_pkg::EL_ONE;
                        wv[nw] = 1'b1;
                        nw = nw + 2'd1;
                        wi = wi + wpm_pkg::IDX_W'(1);
                        ph = (ch == wpm_pkg::CH_STAR) ? PH_STAR : PH_BETWEEN;
                    end
                end
                else if (({1'b0, wi} + (wpm_pkg::IDX_W+1)'(1)) >= {1'b0, wpm_pkg::LIMIT})
                begin
                    ph = PH_ERROR;
                    rc = 8'(wpm_pkg::ST_TOO_LONG);
                    esc = 1'b0;
                end
                else
                begin
                    hi = wi;
                    wa[nw] = hi;
                    wd[nw] = (ch == wpm_pkg::CH_LBRACK) ? wpm_pkg::EL_SET : wpm_pkg::EL_TEXT;
                    wv[nw] = 1'b1;
                    nw = nw + 2'd1;
                    wa[nw] = hi + wpm_pkg::IDX_W'(1);
                    wd[nw] = 8'd0;
                    wv[nw] = 1'b1;
                    nw = nw + 2'd1;
                    wi = wi + wpm_pkg::IDX_W'(2);
                    rc = 8'd0;
                    if (ch == wpm_pkg::CH_LBRACK)
                    begin
                        ph = PH_SET_START;
                        nset = 1'b0;
                    end
                    else
                    begin
                        ph = PH_RUN;
                        rb = 1'b1;
                    end
                end
            end

            if (rb)
            begin
                if (wi >= wpm_pkg::LIMIT)
                begin
                    ph = PH_ERROR;
                    rc = 8'(wpm_pkg::ST_TOO_LONG);
                    esc = 1'b0;
                end
                else if (ch == wpm_pkg::CH_BSLASH)
                begin
                    esc = 1'b1;
                end
                else
                begin
                    ap = 1'b1;
                end
            end

            if (ap)
            begin
                wa[nw] = wi;
                wd[nw] = ch;
                wv[nw] = 1'b1;
                nw = nw + 2'd1;
                wi = wi + wpm_pkg::IDX_W'(1);
                rc = rc + 8'd1;
                wa[nw] = hi + wpm_pkg::IDX_W'(1);
                wd[nw] = rc;
                wv[nw] = 1'b1;
                nw = nw + 2'd1;
            end
        end

        if (last)
        begin
            if (ph == PH_IDLE)
            begin
                st = pv ? wpm_pkg::ST_OK : wpm_pkg::ST_NO_PREV;
            end
            else
            begin
                priority case (ph)
                    PH_ERROR:     st = rc[2:0];
                    PH_SET_START: st = wpm_pkg::ST_PREMATURE;
                    PH_SET_BODY:  st = wpm_pkg::ST_NO_BRACKET;
                    default:      st = wpm_pkg::ST_OK;
                endcase
                pv = (st == wpm_pkg::ST_OK);
                ph = PH_IDLE;
                esc = 1'b0;
            end
        end

        phase_next = ph;
        wi_next = wi;
        hi_next = hi;
        rc_next = rc;
        esc_next = esc;
        nset_next = nset;
        pv_next = pv;
        st_next = st;
        we_next = wv;
        wa_next = wa;
        wd_next = wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            wi_reg <= '0;
            hi_reg <= '0;
            rc_reg <= 8'd0;
            esc_reg <= 1'b0;
            nset_reg <= 1'b0;
            pv_reg <= 1'b0;
            st_reg <= wpm_pkg::ST_OK;
            we_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            wi_reg <= wi_next;
            hi_reg <= hi_next;
            rc_reg <= rc_next;
            esc_reg <= esc_next;
            nset_reg <= nset_next;
            pv_reg <= pv_next;
            st_reg <= st_next;
            we_reg <= we_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            wa_reg <= wa_next;
            wd_reg <= wd_next;
        end
    end

    assign cpl.we = we_reg;
    assign cpl.addr = wa_reg;
    assign cpl.data = wd_reg;
    assign cpl.pvalid = pv_reg;
    assign cpl.end_idx = wi_reg;
    assign cpl.status = st_reg;

endmodule

FILE: hw/rtl/wildcard_pattern_matcher.sv
// Items enter on start while busy is low; a word with last set returns one result on done for
// exactly one cycle, and the receiver cannot stall it. A pattern byte takes a compile step plus
// four store-write slots. A text byte walks the compiled chain once through the pattern store's
// read port, visiting each element head and then each run or set byte, in a store of up to 1024
// entries. The last text word then yields its result through S_FIN and S_FIN2 and, if any
// text byte walked the chain, a clear of the active bits from entry 0 through the chain end; a
// pattern word that cuts into such a text pays the same clear first. After reset all 1024
// entries of the active-bit memories are cleared while busy is high.
`include "assert_macros.svh"

module wildcard_pattern_matcher (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       command,
    input  logic [7:0] data_byte,
    input  logic       no_byte,
    input  logic       last,
    output logic       done,
    output logic       result_kind,
    output logic [2:0] status
);

    localparam int IW = wpm_pkg::IDX_W;

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_CPL   = 13'b0000000000100,
        S_CWR   = 13'b0000000001000,
        S_WH    = 13'b0000000010000,
        S_WK    = 13'b0000000100000,
        S_WN    = 13'b0000001000000,
        S_RUN   = 13'b0000010000000,
        S_SET   = 13'b0000100000000,
        S_SETD  = 13'b0001000000000,
        S_WEND  = 13'b0010000000000,
        S_FIN   = 13'b0100000000000,
        S_FIN2  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [IW-1:0] h_reg, h_next;
    logic [IW-1:0] q_reg, q_next;
    logic [IW-1:0] nx_reg, nx_next;
    logic [7:0] n_reg, n_next;
    logic [7:0] j_reg, j_next;
    logic [7:0] kind_reg, kind_next;
    logic carry_reg, carry_next;
    logic live_reg, live_next;
    logic endset_reg, endset_next;
    logic fresh_reg, fresh_next;
    logic topen_reg, topen_next;
    logic sel_reg, sel_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] lim_reg, lim_next;
    logic cafter_reg, cafter_next;
    logic [1:0] slot_reg, slot_next;
    logic done_reg, done_next;
    logic rkind_reg, rkind_next;
    logic [2:0] status_reg, status_next;
    logic [7:0] item_data_reg;
    logic item_none_reg;
    logic item_last_reg;

    logic accept;
    logic none_in;
    logic cpl_step;
    wpm_pkg::cpl_out_t cpl;
    wpm_pkg::set_ctl_t set_ctl;
    logic set_hit;

    logic [7:0] pmem [wpm_pkg::PATTERN_BYTES];
    logic [7:0] p_rdata;
    logic [IW-1:0] p_raddr, p_waddr;
    logic [7:0] p_wdata;
    logic p_we;

    logic amem0 [wpm_pkg::PATTERN_BYTES];
    logic amem1 [wpm_pkg::PATTERN_BYTES];
    logic a_rd0, a_rd1;
    logic [IW-1:0] a_raddr;
    logic a0_we, a1_we, a0_wdata, a1_wdata;
    logic [IW-1:0] a0_waddr, a1_waddr;
    logic cur_we, prev_we, swp_we;
    logic [IW-1:0] cur_waddr, prev_waddr;
    logic pbit_mem;
    logic live_now;
    logic [IW-1:0] nx_now;

    assign accept = start && !busy;
    assign none_in = no_byte || (data_byte == 8'd0);
    assign busy = (state_reg != S_IDLE);
    assign pbit_mem = sel_reg ? a_rd1 : a_rd0;
    assign live_now = pbit_mem || carry_reg || (fresh_reg && h_reg == '0);
    assign nx_now = h_reg + IW'(2) + IW'(p_rdata);

    wpm_compiler u_compiler (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (cpl_step),
        .ch      (item_data_reg),
        .no_char (item_none_reg),
        .last    (item_last_reg),
        .cpl     (cpl)
    );

    wpm_set_unit u_set_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (set_ctl),
        .data  (p_rdata),
        .key   (item_data_reg),
        .hit   (set_hit)
    );

    always_comb
    begin
        state_next = state_reg;
        h_next = h_reg;
        q_next = q_reg;
        nx_next = nx_reg;
        n_next = n_reg;
        j_next = j_reg;
        kind_next = kind_reg;
        carry_next = carry_reg;
        live_next = live_reg;
        endset_next = endset_reg;
        fresh_next = fresh_reg;
        topen_next = topen_reg;
        sel_next = sel_reg;
        cnt_next = cnt_reg;
        lim_next = lim_reg;
        cafter_next = cafter_reg;
        slot_next = slot_reg;
        done_next = 1'b0;
        rkind_next = rkind_reg;
        status_next = status_reg;
        p_raddr = h_reg;
        a_raddr = h_reg;
        p_we = 1'b0;
        p_waddr = cpl.addr[slot_reg];
        p_wdata = cpl.data[slot_reg];
        cur_we = 1'b0;
        cur_waddr = h_reg;
        prev_we = 1'b0;
        prev_waddr = h_reg;
        swp_we = 1'b0;
        cpl_step = 1'b0;
        set_ctl = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                swp_we = 1'b1;
                cnt_next = cnt_reg + IW'(1);
                if (cnt_reg == lim_reg)
                begin
                    fresh_next = 1'b1;
                    state_next = cafter_reg ? S_CPL : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (command == wpm_pkg::CMD_PATTERN)
                    begin
                        topen_next = 1'b0;
                        if (topen_reg && !fresh_reg)
                        begin
                            cnt_next = '0;
                            lim_next = cpl.end_idx;
                            cafter_next = 1'b1;
                            state_next = S_CLEAR;
                        end
                        else
                        begin
                            state_next = S_CPL;
                        end
                    end
                    else
                    begin
                        topen_next = 1'b1;
                        if (!topen_reg)
                        begin
                            fresh_next = 1'b1;
                        end
                        if (!none_in && cpl.pvalid)
                        begin
                            h_next = '0;
                            carry_next = 1'b0;
                            endset_next = 1'b0;
                            state_next = S_WH;
                        end
                        else if (last)
                        begin
                            state_next = S_FIN;
                        end
                    end
                end
            end
            S_CPL:
            begin
                cpl_step = 1'b1;
                slot_next = 2'd0;
                state_next = S_CWR;
            end
            S_CWR:
            begin
                p_we = cpl.we[slot_reg];
                slot_next = slot_reg + 2'd1;
                if (slot_reg == 2'd3)
                begin
                    if (item_last_reg)
                    begin
                        done_next = 1'b1;
                        rkind_next = wpm_pkg::KIND_COMPILE;
                        status_next = cpl.status;
                    end
                    state_next = S_IDLE;
                end
            end
            S_WH:
            begin
                if (h_reg >= cpl.end_idx)
                begin
                    state_next = S_WEND;
                end
                else
                begin
                    state_next = S_WK;
                end
            end
            S_WK:
            begin
                prev_we = 1'b1;
                p_raddr = h_reg + IW'(1);
                kind_next = p_rdata;
                live_next = live_now;
                carry_next = 1'b0;
                h_next = h_reg + IW'(1);
                state_next = S_WH;
                unique case (p_rdata)
                    wpm_pkg::EL_ANY:
                    begin
                        if (live_now)
                        begin
                            cur_we = 1'b1;
                            carry_next = 1'b1;
                            if (h_reg + IW'(1) == cpl.end_idx)
                            begin
                                endset_next = 1'b1;
                            end
                        end
                    end
                    wpm_pkg::EL_ONE:
                    begin
                        cur_we = live_now;
                        cur_waddr = h_reg + IW'(1);
                    end
                    wpm_pkg::EL_TEXT, wpm_pkg::EL_SET, wpm_pkg::EL_NSET:
                    begin
                        h_next = h_reg;
                        state_next = S_WN;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_WN:
            begin
                n_next = p_rdata;
                nx_next = nx_now;
                j_next = 8'd0;
                q_next = h_reg + IW'(2);
                p_raddr = h_reg + IW'(2);
                a_raddr = h_reg + IW'(2);
                if (kind_reg == wpm_pkg::EL_TEXT)
                begin
                    if (p_rdata == 8'd0)
                    begin
                        carry_next = live_reg;
                        h_next = nx_now;
                        state_next = S_WH;
                    end
                    else
                    begin
                        state_next = S_RUN;
                    end
                end
                else if (!live_reg)
                begin
                    h_next = nx_now;
                    state_next = S_WH;
                end
                else if (p_rdata == 8'd0)
                begin
                    cur_we = (kind_reg == wpm_pkg::EL_NSET);
                    cur_waddr = nx_now;
                    h_next = nx_now;
                    state_next = S_WH;
                end
                else
                begin
                    set_ctl.clr = 1'b1;
                    state_next = S_SET;
                end
            end
            S_RUN:
            begin
                prev_we = 1'b1;
                prev_waddr = q_reg;
                if (((j_reg == 8'd0) ? live_reg : (pbit_mem && !fresh_reg)) &&
                    item_data_reg == p_rdata)
                begin
                    cur_we = 1'b1;
                end
                cur_waddr = (j_reg + 8'd1 == n_reg) ? nx_reg : q_reg + IW'(1);
                j_next = j_reg + 8'd1;
                q_next = q_reg + IW'(1);
                p_raddr = q_reg + IW'(1);
                a_raddr = q_reg + IW'(1);
                if (j_reg + 8'd1 == n_reg)
                begin
                    h_next = nx_reg;
                    state_next = S_WH;
                end
            end
            S_SET:
            begin
                set_ctl.shift = 1'b1;
                j_next = j_reg + 8'd1;
                q_next = q_reg + IW'(1);
                p_raddr = q_reg + IW'(1);
                if (j_reg + 8'd1 == n_reg)
                begin
                    state_next = S_SETD;
                end
            end
            S_SETD:
            begin
                cur_we = (set_hit == (kind_reg == wpm_pkg::EL_SET));
                cur_waddr = nx_reg;
                h_next = nx_reg;
                state_next = S_WH;
            end
            S_WEND:
            begin
                cur_we = endset_reg;
                cur_waddr = cpl.end_idx;
                prev_we = 1'b1;
                prev_waddr = cpl.end_idx;
                sel_next = !sel_reg;
                fresh_next = 1'b0;
                endset_next = 1'b0;
                state_next = item_last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                a_raddr = cpl.end_idx;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                done_next = 1'b1;
                rkind_next = wpm_pkg::KIND_MATCH;
                if (!cpl.pvalid)
                begin
                    status_next = wpm_pkg::MT_NO_PATTERN;
                end
                else
                begin
                    status_next = pbit_mem ? wpm_pkg::MT_YES : wpm_pkg::MT_NO;
                end
                topen_next = 1'b0;
                if (!fresh_reg)
                begin
                    cnt_next = '0;
                    lim_next = cpl.end_idx;
                    cafter_next = 1'b0;
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // prev buffer is the one sel points at, new bits go to the other
    always_comb
    begin
        if (swp_we)
        begin
            a0_we = 1'b1;
            a1_we = 1'b1;
            a0_waddr = cnt_reg;
            a1_waddr = cnt_reg;
            a0_wdata = 1'b0;
            a1_wdata = 1'b0;
        end
        else if (sel_reg)
        begin
            a0_we = cur_we;
            a0_waddr = cur_waddr;
            a0_wdata = 1'b1;
            a1_we = prev_we;
            a1_waddr = prev_waddr;
            a1_wdata = 1'b0;
        end
        else
        begin
            a1_we = cur_we;
            a1_waddr = cur_waddr;
            a1_wdata = 1'b1;
            a0_we = prev_we;
            a0_waddr = prev_waddr;
            a0_wdata = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        p_rdata <= pmem[p_raddr];
        if (p_we)
        begin
            pmem[p_waddr] <= p_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        a_rd0 <= amem0[a_raddr];
        a_rd1 <= amem1[a_raddr];
        if (a0_we)
        begin
            amem0[a0_waddr] <= a0_wdata;
        end
        if (a1_we)
        begin
            amem1[a1_waddr] <= a1_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            carry_reg <= 1'b0;
            live_reg <= 1'b0;
            endset_reg <= 1'b0;
            fresh_reg <= 1'b1;
            topen_reg <= 1'b0;
            sel_reg <= 1'b0;
            cnt_reg <= '0;
            lim_reg <= wpm_pkg::LAST_IDX;
            cafter_reg <= 1'b0;
            slot_reg <= 2'd0;
            done_reg <= 1'b0;
            rkind_reg <= wpm_pkg::KIND_COMPILE;
            status_reg <= wpm_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            carry_reg <= carry_next;
            live_reg <= live_next;
            endset_reg <= endset_next;
            fresh_reg <= fresh_next;
            topen_reg <= topen_next;
            sel_reg <= sel_next;
            cnt_reg <= cnt_next;
            lim_reg <= lim_next;
            cafter_reg <= cafter_next;
            slot_reg <= slot_next;
            done_reg <= done_next;
            rkind_reg <= rkind_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        q_reg <= q_next;
        nx_reg <= nx_next;
        n_reg <= n_next;
        j_reg <= j_next;
        kind_reg <= kind_next;
        if (accept)
        begin
            item_data_reg <= data_byte;
            item_none_reg <= none_in;
            item_last_reg <= last;
        end
    end

    assign done = done_reg;
    assign result_kind = rkind_reg;
    assign status = status_reg;

    `ASSERT_PROP(a_done_single, done |=> !done, "done held longer than one cycle")
    `ASSERT_PROP(a_walk_bound, (state_reg == S_WK) |-> (h_reg < cpl.end_idx),
                 "chain walk past end of pattern")
    `ASSERT_NEVER(a_match_code, done && result_kind == wpm_pkg::KIND_MATCH &&
                  status != wpm_pkg::MT_NO && status != wpm_pkg::MT_YES &&
                  status != wpm_pkg::MT_NO_PATTERN, "bad match status")

endmodule
